@@ src/ttc_pkg.sv @@
// Shared widths, job and status types, and saturation limits of the tangent unit.
`default_nettype none

package ttc_pkg;

   localparam int POS_W     = 32;  // Q16.16 position and tangent
   localparam int UV_W      = 24;  // Q8.16 texture coordinate
   localparam int DPOS_W    = POS_W + 1;
   localparam int DUV_W     = UV_W + 1;
   localparam int PROD_W    = DPOS_W + DUV_W;
   localparam int DET_W     = 2 * DUV_W + 1;
   localparam int NUM_W     = PROD_W + 1;
   localparam int FRAC_W    = 16;
   localparam int QUO_W     = POS_W + 1;
   localparam int AXES      = 3;
   localparam int NUM_PRODS = 8;
   localparam int MCNT_W    = 4;
   localparam int STEP_W    = 6;

   localparam logic [QUO_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [QUO_W-1:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [POS_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] SAT_MIN   = 32'h8000_0000;

   typedef logic signed [DPOS_W-1:0] dpos_type;
   typedef logic signed [DUV_W-1:0]  duv_type;

   // Edge and texture deltas of one triangle, as handed from front to back.
   typedef struct packed {
      dpos_type [AXES-1:0] dp1;
      dpos_type [AXES-1:0] dp2;
      duv_type             du1;
      duv_type             dv1;
      duv_type             du2;
      duv_type             dv2;
   } job_type;

   typedef struct packed {
      logic [POS_W-1:0] value;
      logic             clip;
      logic             done;
   } lane_status_type;

endpackage

`default_nettype wire

@@ src/ttc_front.sv @@
// Front end: holds the first two corners and turns the third into a job of deltas.
`default_nettype none

module ttc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_z,
   input  wire logic signed [ttc_pkg::UV_W-1:0]   req_tex_u,
   input  wire logic signed [ttc_pkg::UV_W-1:0]   req_tex_v,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output ttc_pkg::job_type                       push_data
);

   localparam logic [1:0] CORNER_FIRST = 2'd0;
   localparam logic [1:0] CORNER_LAST  = 2'd2;

   logic [1:0] count_ff, count_in;
   logic signed [ttc_pkg::POS_W-1:0] pos_ff [0:1][0:ttc_pkg::AXES-1];
   logic signed [ttc_pkg::UV_W-1:0]  u_ff [0:1];
   logic signed [ttc_pkg::UV_W-1:0]  v_ff [0:1];
   logic signed [ttc_pkg::POS_W-1:0] in_pos [0:ttc_pkg::AXES-1];
   logic accept;
   logic last;

   assign in_pos[0] = req_pos_x;
   assign in_pos[1] = req_pos_y;
   assign in_pos[2] = req_pos_z;

   assign last       = (count_ff == CORNER_LAST);
   assign req_stall  = last && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = req_valid && last;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last ? CORNER_FIRST : count_ff + 2'd1;
      end
   end

   always_comb begin
      for (int a = 0; a < ttc_pkg::AXES; a++) begin
         push_data.dp1[a] = ttc_pkg::DPOS_W'(pos_ff[1][a]) - ttc_pkg::DPOS_W'(pos_ff[0][a]);
         push_data.dp2[a] = ttc_pkg::DPOS_W'(in_pos[a]) - ttc_pkg::DPOS_W'(pos_ff[0][a]);
      end
      push_data.du1 = ttc_pkg::DUV_W'(u_ff[1]) - ttc_pkg::DUV_W'(u_ff[0]);
      push_data.dv1 = ttc_pkg::DUV_W'(v_ff[1]) - ttc_pkg::DUV_W'(v_ff[0]);
      push_data.du2 = ttc_pkg::DUV_W'(req_tex_u) - ttc_pkg::DUV_W'(u_ff[0]);
      push_data.dv2 = ttc_pkg::DUV_W'(req_tex_v) - ttc_pkg::DUV_W'(v_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CORNER_FIRST;
      end else begin
         count_ff <= count_in;
      end
   end

   // Corner slots need no reset: the count gates every read.
   always_ff @(posedge clock) begin
      if (accept && !last) begin
         for (int a = 0; a < ttc_pkg::AXES; a++) begin
            pos_ff[count_ff[0]][a] <= in_pos[a];
         end
         u_ff[count_ff[0]] <= req_tex_u;
         v_ff[count_ff[0]] <= req_tex_v;
      end
   end

endmodule

`default_nettype wire

@@ src/ttc_queue.sv @@
// Small job queue between the front end and the arithmetic back end.
`default_nettype none

module ttc_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire ttc_pkg::job_type  push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output ttc_pkg::job_type       pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ttc_pkg::job_type entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/ttc_div_lane.sv @@
// One restoring divider lane: magnitude quotient in Q16.16 with saturation, one bit a cycle.
`default_nettype none

module ttc_div_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ttc_pkg::NUM_W-1:0]      num_mag,
   input  wire logic [ttc_pkg::DET_W-1:0]      den_mag,
   input  wire logic                           neg,
   output ttc_pkg::lane_status_type            status
);

   localparam int CMP_W  = ttc_pkg::DET_W + ttc_pkg::FRAC_W + 1;
   localparam int TRY_W  = ttc_pkg::DET_W + 1;

   logic [ttc_pkg::DET_W-1:0]  rem_ff, rem_in;
   logic [ttc_pkg::DET_W-1:0]  den_ff, den_in;
   logic [ttc_pkg::QUO_W-1:0]  bits_ff, bits_in;
   logic [ttc_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [ttc_pkg::STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic ovf_ff, ovf_in;
   logic [TRY_W-1:0] trial;
   logic fits;
   logic clip;

   assign trial = {rem_ff, bits_ff[ttc_pkg::QUO_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         // A quotient of 2^33 or more saturates whatever its sign.
         ovf_in  = CMP_W'(num_mag) >= {den_mag, {(ttc_pkg::FRAC_W + 1){1'b0}}};
         rem_in  = ttc_pkg::DET_W'(num_mag >> (ttc_pkg::FRAC_W + 1));
         bits_in = {num_mag[ttc_pkg::FRAC_W:0], {ttc_pkg::FRAC_W{1'b0}}};
         den_in  = den_mag;
         neg_in  = neg;
         quo_in  = '0;
         step_in = ttc_pkg::STEP_W'(ttc_pkg::QUO_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? ttc_pkg::DET_W'(trial - {1'b0, den_ff}) : ttc_pkg::DET_W'(trial);
         quo_in  = {quo_ff[ttc_pkg::QUO_W-2:0], fits};
         bits_in = bits_ff << 1;
         step_in = step_ff - 1'b1;
         if (step_ff == ttc_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
   end

   // A negative result may reach one step further than a positive one.
   assign clip = ovf_ff || (neg_ff ? (quo_ff > ttc_pkg::NEG_LIMIT)
                                   : (quo_ff > ttc_pkg::POS_LIMIT));

   always_comb begin
      status.done = done_ff;
      status.clip = clip;
      if (clip) begin
         status.value = neg_ff ? ttc_pkg::SAT_MIN : ttc_pkg::SAT_MAX;
      end else if (neg_ff) begin
         status.value = -quo_ff[ttc_pkg::POS_W-1:0];
      end else begin
         status.value = quo_ff[ttc_pkg::POS_W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ src/ttc_back.sv @@
// Back end: shared multiplier for determinant and numerators, three divider lanes, result register.
`default_nettype none

module ttc_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            pop_valid,
   output logic                                 pop_ready,
   input  wire ttc_pkg::job_type                pop_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [ttc_pkg::POS_W-1:0]     rsp_tangent_x,
   output logic signed [ttc_pkg::POS_W-1:0]     rsp_tangent_y,
   output logic signed [ttc_pkg::POS_W-1:0]     rsp_tangent_z,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_clipped
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL    = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_LAUNCH = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_WRITE  = 6'b100000
   } back_state_type;

   localparam int AX = ttc_pkg::AXES;

   back_state_type state_ff, state_in;
   ttc_pkg::job_type job_ff, job_in;
   logic [ttc_pkg::MCNT_W-1:0]         mcnt_ff, mcnt_in;
   logic signed [ttc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ttc_pkg::DET_W-1:0]   det_ff, det_in;
   logic signed [ttc_pkg::NUM_W-1:0]   num_ff [0:AX-1];
   logic signed [ttc_pkg::NUM_W-1:0]   num_in [0:AX-1];
   logic [ttc_pkg::DET_W-1:0]          den_mag_ff, den_mag_in;
   logic [ttc_pkg::NUM_W-1:0]          num_mag_ff [0:AX-1];
   logic [ttc_pkg::NUM_W-1:0]          num_mag_in [0:AX-1];
   logic                               neg_ff [0:AX-1];
   logic                               neg_in [0:AX-1];
   logic degen_ff, degen_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ttc_pkg::POS_W-1:0]          tan_ff [0:AX-1];
   logic [ttc_pkg::POS_W-1:0]          tan_in [0:AX-1];
   logic rsp_degen_ff, rsp_degen_in;
   logic rsp_clip_ff, rsp_clip_in;

   ttc_pkg::dpos_type mul_a;
   ttc_pkg::duv_type  mul_b;
   ttc_pkg::lane_status_type lane_st [0:AX-1];
   logic lane_start;
   logic all_done;
   logic any_clip;
   logic out_free;

   assign pop_ready  = (state_ff == ST_IDLE);
   assign lane_start = (state_ff == ST_LAUNCH);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      all_done = 1'b1;
      any_clip = 1'b0;
      for (int a = 0; a < AX; a++) begin
         all_done = all_done && lane_st[a].done;
         any_clip = any_clip || lane_st[a].clip;
      end
   end

   // Product order: du1*dv2, dv1*du2, then dp1*dv2 and dp2*dv1 for each axis.
   always_comb begin
      mul_a = ttc_pkg::DPOS_W'(job_ff.du1);
      mul_b = job_ff.dv2;
      if (mcnt_ff == ttc_pkg::MCNT_W'(1)) begin
         mul_a = ttc_pkg::DPOS_W'(job_ff.dv1);
         mul_b = job_ff.du2;
      end
      for (int a = 0; a < AX; a++) begin
         if (mcnt_ff == ttc_pkg::MCNT_W'(2 * a + 2)) begin
            mul_a = job_ff.dp1[a];
            mul_b = job_ff.dv2;
         end else if (mcnt_ff == ttc_pkg::MCNT_W'(2 * a + 3)) begin
            mul_a = job_ff.dp2[a];
            mul_b = job_ff.dv1;
         end
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      mcnt_in      = mcnt_ff;
      det_in       = det_ff;
      den_mag_in   = den_mag_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_degen_in = rsp_degen_ff;
      rsp_clip_in  = rsp_clip_ff;
      for (int a = 0; a < AX; a++) begin
         num_in[a]     = num_ff[a];
         num_mag_in[a] = num_mag_ff[a];
         neg_in[a]     = neg_ff[a];
         tan_in[a]     = tan_ff[a];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_data;
               mcnt_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The product issued at count k is accumulated at count k + 1.
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == ttc_pkg::MCNT_W'(1)) begin
               det_in = ttc_pkg::DET_W'(prod_ff);
            end else if (mcnt_ff == ttc_pkg::MCNT_W'(2)) begin
               det_in = det_ff - ttc_pkg::DET_W'(prod_ff);
            end
            for (int a = 0; a < AX; a++) begin
               if (mcnt_ff == ttc_pkg::MCNT_W'(2 * a + 3)) begin
                  num_in[a] = ttc_pkg::NUM_W'(prod_ff);
               end else if (mcnt_ff == ttc_pkg::MCNT_W'(2 * a + 4)) begin
                  num_in[a] = num_ff[a] - ttc_pkg::NUM_W'(prod_ff);
               end
            end
            if (mcnt_ff == ttc_pkg::MCNT_W'(ttc_pkg::NUM_PRODS)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            den_mag_in = det_ff[ttc_pkg::DET_W-1] ? ttc_pkg::DET_W'(-det_ff)
                                                  : ttc_pkg::DET_W'(det_ff);
            degen_in   = (det_ff == '0);
            for (int a = 0; a < AX; a++) begin
               num_mag_in[a] = num_ff[a][ttc_pkg::NUM_W-1] ? ttc_pkg::NUM_W'(-num_ff[a])
                                                           : ttc_pkg::NUM_W'(num_ff[a]);
               neg_in[a]     = num_ff[a][ttc_pkg::NUM_W-1] ^ det_ff[ttc_pkg::DET_W-1];
            end
            state_in = (det_ff == '0) ? ST_WRITE : ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (all_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_degen_in = degen_ff;
               rsp_clip_in  = !degen_ff && any_clip;
               for (int a = 0; a < AX; a++) begin
                  tan_in[a] = degen_ff ? '0 : lane_st[a].value;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      mcnt_ff      <= mcnt_in;
      prod_ff      <= prod_in;
      det_ff       <= det_in;
      den_mag_ff   <= den_mag_in;
      degen_ff     <= degen_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_clip_ff  <= rsp_clip_in;
      for (int a = 0; a < AX; a++) begin
         num_ff[a]     <= num_in[a];
         num_mag_ff[a] <= num_mag_in[a];
         neg_ff[a]     <= neg_in[a];
         tan_ff[a]     <= tan_in[a];
      end
   end

   for (genvar g = 0; g < AX; g++) begin : g_lane
      ttc_div_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (lane_start),
         .num_mag (num_mag_ff[g]),
         .den_mag (den_mag_ff),
         .neg     (neg_ff[g]),
         .status  (lane_st[g])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tangent_x  = tan_ff[0];
   assign rsp_tangent_y  = tan_ff[1];
   assign rsp_tangent_z  = tan_ff[2];
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_clipped    = rsp_clip_ff;

endmodule

`default_nettype wire

@@ src/triangle_tangent_calc_unit.sv @@
// Triangle tangent unit: corners in, one tangent vector per triangle out.
//
// Corners arrive on the req_ channel, one per item, with position in Q16.16 and
// texture coordinate in Q8.16. Every third corner closes a triangle and yields one
// item on the rsp_ channel: tangent x, y, z in Q16.16, a degenerate flag (zero UV
// determinant, tangent zero) and a clipped flag (some component saturated).
// The first two corners of a triangle are always taken when offered. The
// third is held off by req_stall only while the job queue is full.
// From the third corner the job goes through the queue, then the shared 33x25
// multiplier, the setup states ST_PREP and ST_LAUNCH, the bit-serial divider lanes
// (one per axis, in parallel), ST_DIV seeing the lanes done, and ST_WRITE loading
// the result register. A triangle with zero determinant skips the divide.
// The back end holds one triangle at a time; its rate is set by the 33-step
// divider lanes and the eight products through the one multiplier.
// When rsp_stall is high the result stays in its register and the back end waits
// to write the next one; the front end keeps taking corners until the queue fills.
// Synchronous reset empties the queue, drops any partial triangle and clears rsp_valid.
`default_nettype none

module triangle_tangent_calc_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [ttc_pkg::POS_W-1:0]  req_pos_z,
   input  wire logic signed [ttc_pkg::UV_W-1:0]   req_tex_u,
   input  wire logic signed [ttc_pkg::UV_W-1:0]   req_tex_v,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [ttc_pkg::POS_W-1:0]       rsp_tangent_x,
   output logic signed [ttc_pkg::POS_W-1:0]       rsp_tangent_y,
   output logic signed [ttc_pkg::POS_W-1:0]       rsp_tangent_z,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_clipped
);

   logic q_push_valid, q_push_ready;
   logic q_pop_valid, q_pop_ready;
   ttc_pkg::job_type q_push_data, q_pop_data;

   ttc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .req_tex_u  (req_tex_u),
      .req_tex_v  (req_tex_v),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   ttc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   ttc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (q_pop_valid),
      .pop_ready      (q_pop_ready),
      .pop_data       (q_pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_clipped    (rsp_clipped)
   );

`ifndef SYNTHESIS
   // The front end holds off corners only when the queue has no room.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_push_ready)
      else $error("req_stall raised while the job queue has room");

   // A job pushed into the queue is visible to the back end on the next cycle.
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push_valid && q_push_ready |=> q_pop_valid)
      else $error("queue empty right after a push");

   // The back end takes one job at a time.
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      q_pop_valid && q_pop_ready |=> !q_pop_ready)
      else $error("back end ready again right after taking a job");
`endif

endmodule

`default_nettype wire

@@ verif/tb_triangle_tangent_calc_unit.sv @@
// Self-checking testbench for the triangle tangent unit.
`default_nettype none

module tb_triangle_tangent_calc_unit;

   localparam logic signed [ttc_pkg::POS_W-1:0] POS_ONE = 32'sh0001_0000;
   localparam logic signed [ttc_pkg::POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ttc_pkg::POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [ttc_pkg::UV_W-1:0]  UV_ONE  = 24'sh01_0000;
   localparam logic signed [ttc_pkg::UV_W-1:0]  UV_MAX  = 24'sh7F_FFFF;
   localparam logic signed [ttc_pkg::UV_W-1:0]  UV_MIN  = 24'sh80_0000;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic signed [ttc_pkg::POS_W-1:0] pos_x;
      logic signed [ttc_pkg::POS_W-1:0] pos_y;
      logic signed [ttc_pkg::POS_W-1:0] pos_z;
      logic signed [ttc_pkg::UV_W-1:0]  tex_u;
      logic signed [ttc_pkg::UV_W-1:0]  tex_v;
   } corner_type;

   typedef struct packed {
      logic signed [ttc_pkg::POS_W-1:0] tangent_x;
      logic signed [ttc_pkg::POS_W-1:0] tangent_y;
      logic signed [ttc_pkg::POS_W-1:0] tangent_z;
      logic                             degenerate;
      logic                             clipped;
   } tangent_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [ttc_pkg::POS_W-1:0] req_pos_x;
   logic signed [ttc_pkg::POS_W-1:0] req_pos_y;
   logic signed [ttc_pkg::POS_W-1:0] req_pos_z;
   logic signed [ttc_pkg::UV_W-1:0]  req_tex_u;
   logic signed [ttc_pkg::UV_W-1:0]  req_tex_v;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [ttc_pkg::POS_W-1:0] rsp_tangent_x;
   logic signed [ttc_pkg::POS_W-1:0] rsp_tangent_y;
   logic signed [ttc_pkg::POS_W-1:0] rsp_tangent_z;
   logic rsp_degenerate;
   logic rsp_clipped;

   // Corners of the triangle in progress, as seen by the block.
   corner_type  held_corner[2];
   int          corners_held;
   tangent_type expected_tangents[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int quiet_cycles;
   int error_count;
   int corners_sent;
   int tangents_checked;
   int degenerate_count;
   int clipped_count;
   int input_stall_cycles;

   triangle_tangent_calc_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_clipped    (rsp_clipped)
   );

   always #5 clock = ~clock;

   // Exact tangent of one triangle: the quotient is formed on magnitudes with
   // enough width that nothing is lost, truncated toward zero, then saturated.
   function automatic tangent_type tangent_of_triangle(corner_type c0, corner_type c1,
                                                       corner_type c2);
      tangent_type               t;
      longint                    p0[ttc_pkg::AXES];
      longint                    p1[ttc_pkg::AXES];
      longint                    p2[ttc_pkg::AXES];
      longint                    u[3];
      longint                    v[3];
      longint                    du1, dv1, du2, dv2, det, num;
      logic [95:0]               mag_num, mag_det, quo;
      logic                      neg;
      logic [ttc_pkg::POS_W-1:0] lane_value[ttc_pkg::AXES];
      t = '0;
      p0[0] = signed'(c0.pos_x);
      p0[1] = signed'(c0.pos_y);
      p0[2] = signed'(c0.pos_z);
      p1[0] = signed'(c1.pos_x);
      p1[1] = signed'(c1.pos_y);
      p1[2] = signed'(c1.pos_z);
      p2[0] = signed'(c2.pos_x);
      p2[1] = signed'(c2.pos_y);
      p2[2] = signed'(c2.pos_z);
      u[0] = signed'(c0.tex_u);
      u[1] = signed'(c1.tex_u);
      u[2] = signed'(c2.tex_u);
      v[0] = signed'(c0.tex_v);
      v[1] = signed'(c1.tex_v);
      v[2] = signed'(c2.tex_v);
      du1 = u[1] - u[0];
      dv1 = v[1] - v[0];
      du2 = u[2] - u[0];
      dv2 = v[2] - v[0];
      det = du1 * dv2 - dv1 * du2;
      if (det == 0) begin
         t.degenerate = 1'b1;
         return t;
      end
      for (int a = 0; a < ttc_pkg::AXES; a++) begin
         num = (p1[a] - p0[a]) * dv2 - (p2[a] - p0[a]) * dv1;
         neg = (num < 0) != (det < 0);
         mag_num = (num < 0) ? -num : num;
         mag_det = (det < 0) ? -det : det;
         quo = (mag_num << ttc_pkg::FRAC_W) / mag_det;
         if (!neg && quo > 96'h7FFF_FFFF) begin
            lane_value[a] = ttc_pkg::SAT_MAX;
            t.clipped = 1'b1;
         end else if (neg && quo > 96'h8000_0000) begin
            lane_value[a] = ttc_pkg::SAT_MIN;
            t.clipped = 1'b1;
         end else begin
            lane_value[a] = neg ? (~quo[ttc_pkg::POS_W-1:0] + 1'b1)
                                : quo[ttc_pkg::POS_W-1:0];
         end
      end
      t.tangent_x = lane_value[0];
      t.tangent_y = lane_value[1];
      t.tangent_z = lane_value[2];
      return t;
   endfunction

   function automatic corner_type make_corner(logic signed [ttc_pkg::POS_W-1:0] px,
                                              logic signed [ttc_pkg::POS_W-1:0] py,
                                              logic signed [ttc_pkg::POS_W-1:0] pz,
                                              logic signed [ttc_pkg::UV_W-1:0] u,
                                              logic signed [ttc_pkg::UV_W-1:0] v);
      corner_type c;
      c.pos_x = px;
      c.pos_y = py;
      c.pos_z = pz;
      c.tex_u = u;
      c.tex_v = v;
      return c;
   endfunction

   // A signed value narrowed by an arithmetic shift, either uniform or one of a
   // few boundary values.
   function automatic int random_field(int shift, bit edges);
      int raw;
      raw = int'($urandom());
      if (edges) begin
         case ($urandom_range(4))
            0: raw = POS_MIN;
            1: raw = POS_MAX;
            2: raw = 0;
            3: raw = -1;
            default: raw = POS_ONE;
         endcase
      end
      return raw >>> shift;
   endfunction

   function automatic corner_type random_corner(int pos_shift, int uv_shift, bit edges);
      corner_type c;
      c.pos_x = random_field(pos_shift, edges);
      c.pos_y = random_field(pos_shift, edges);
      c.pos_z = random_field(pos_shift, edges);
      c.tex_u = ttc_pkg::UV_W'(random_field(ttc_pkg::POS_W - ttc_pkg::UV_W + uv_shift, edges));
      c.tex_v = ttc_pkg::UV_W'(random_field(ttc_pkg::POS_W - ttc_pkg::UV_W + uv_shift, edges));
      return c;
   endfunction

   // Offers one corner, then follows the block's corner count once it is taken.
   // Returns right after the accepting edge with req_valid still high.
   task automatic send_corner(corner_type c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= c.pos_x;
      req_pos_y <= c.pos_y;
      req_pos_z <= c.pos_z;
      req_tex_u <= c.tex_u;
      req_tex_v <= c.tex_v;
      do @(posedge clock); while (req_stall);
      corners_sent++;
      if (corners_held == 2) begin
         expected_tangents.insert(expected_tangents.size(),
                                  tangent_of_triangle(held_corner[0], held_corner[1], c));
         corners_held = 0;
      end else begin
         held_corner[corners_held] = c;
         corners_held++;
      end
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (expected_tangents.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Known tangents, both degenerate kinds, and the saturation boundaries.
   task automatic test_directed();
      send_corner(make_corner(0, 0, 0, 0, 0));
      send_corner(make_corner(POS_ONE, 0, 0, UV_ONE, 0));
      send_corner(make_corner(0, POS_ONE, 0, 0, UV_ONE));

      send_corner(make_corner(POS_ONE, 2 * POS_ONE, 3 * POS_ONE, 5, 7));
      send_corner(make_corner(-POS_ONE, 9, POS_MAX, 5, 7));
      send_corner(make_corner(POS_MIN, -5, 12, 5, 7));

      send_corner(make_corner(POS_MAX, POS_MIN, POS_ONE, 0, 0));
      send_corner(make_corner(POS_MIN, POS_MAX, -POS_ONE, UV_ONE, UV_ONE));
      send_corner(make_corner(3, -3, 0, 2 * UV_ONE, 2 * UV_ONE));

      // The determinant is one LSB, so the tangent is the edge delta times 2^16:
      // first exactly at the negative limit and just inside the positive one,
      // then one step beyond each.
      send_corner(make_corner(0, 0, 0, 0, 0));
      send_corner(make_corner(-32768, 32767, 0, 1, 0));
      send_corner(make_corner(0, 0, 0, 0, 1));
      send_corner(make_corner(0, 0, 0, 0, 0));
      send_corner(make_corner(-32769, 32768, 0, 1, 0));
      send_corner(make_corner(0, 0, 0, 0, 1));

      send_corner(make_corner(POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MIN));
      send_corner(make_corner(POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MIN));
      send_corner(make_corner(POS_MAX, POS_MAX, POS_MAX, UV_MIN, UV_MAX));

      send_corner(make_corner(POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MAX));
      send_corner(make_corner(POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MAX));
      send_corner(make_corner(POS_MIN, POS_MIN, POS_MIN, UV_MAX, UV_MIN));

      send_corner(make_corner(POS_MAX, POS_MAX, POS_MAX, UV_MAX, UV_MAX));
      send_corner(make_corner(POS_MIN, POS_MIN, POS_MIN, UV_MIN, UV_MIN));
      send_corner(make_corner(0, 0, 0, 0, 0));
      idle_req();
   endtask

   task automatic test_random(int triangles);
      corner_type corners[3];
      int         kind;
      int         j;
      int         k;
      for (int n = 0; n < triangles; n++) begin
         kind = $urandom_range(99);
         for (int i = 0; i < 3; i++) begin
            if (kind < 40) corners[i] = random_corner(0, 0, 1'b0);
            else if (kind < 65) corners[i] = random_corner(11, 11, 1'b0);
            else if (kind < 90) corners[i] = random_corner(0, 0, 1'b0);
            else corners[i] = random_corner(0, 0, 1'b1);
         end
         if (kind >= 65 && kind < 80) begin
            // Texture coordinates a few LSBs apart give a tiny determinant and
            // drive the quotient into saturation.
            for (int i = 1; i < 3; i++) begin
               corners[i].tex_u = ttc_pkg::UV_W'(corners[0].tex_u + $urandom_range(6) - 3);
               corners[i].tex_v = ttc_pkg::UV_W'(corners[0].tex_v + $urandom_range(6) - 3);
            end
         end else if (kind >= 80 && kind < 90) begin
            j = $urandom_range(2);
            k = (j + 1 + $urandom_range(1)) % 3;
            corners[j].tex_u = corners[k].tex_u;
            corners[j].tex_v = corners[k].tex_v;
         end
         for (int i = 0; i < 3; i++) send_corner(corners[i]);
      end
      idle_req();
   endtask

   // The output stalls for a long stretch while corners keep coming, so the job
   // queue fills and the input is held off; then the sender waits for a full drain.
   task automatic test_backpressure();
      @(posedge clock);
      send_idle_pct = 0;
      hold_cycles = HOLD_OFF_CYCLES;
      for (int n = 0; n < 30; n++) send_corner(random_corner(0, 0, 1'b0));
      idle_req();
      wait_drain();
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(string name, logic [ttc_pkg::POS_W-1:0] expected,
                              logic [ttc_pkg::POS_W-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s expected %h, got %h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      tangent_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tangents.size() == 0) begin
            $display("%0t: unexpected tangent item, expected none, got %h %h %h %b %b",
                     $time, rsp_tangent_x, rsp_tangent_y, rsp_tangent_z,
                     rsp_degenerate, rsp_clipped);
            error_count++;
         end else begin
            want = expected_tangents.pop_front();
            check_field("tangent_x", want.tangent_x, rsp_tangent_x);
            check_field("tangent_y", want.tangent_y, rsp_tangent_y);
            check_field("tangent_z", want.tangent_z, rsp_tangent_z);
            check_field("degenerate", want.degenerate, rsp_degenerate);
            check_field("clipped", want.clipped, rsp_clipped);
            tangents_checked++;
            degenerate_count += want.degenerate;
            clipped_count += want.clipped;
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d tangents outstanding",
                     $time, quiet_cycles, expected_tangents.size());
            $display("tb_triangle_tangent_calc_unit: errors");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_tex_u = '0;
      req_tex_v = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      error_count = 0;
      corners_sent = 0;
      corners_held = 0;
      tangents_checked = 0;
      degenerate_count = 0;
      clipped_count = 0;
      input_stall_cycles = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      set_idling(7, 82);
      test_directed();
      test_random(140);
      set_idling(82, 7);
      test_random(140);
      test_backpressure();
      set_idling(0, 0);
      test_random(130);

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d corners; checked %0d tangents, %0d degenerate and %0d saturated.",
               corners_sent, tangents_checked, degenerate_count, clipped_count);
      $display("Input was held off for %0d cycles across idle patterns and a long stall.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("tb_triangle_tangent_calc_unit: clean");
      end else begin
         $display("tb_triangle_tangent_calc_unit: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ttc_pkg.sv
src/ttc_front.sv
src/ttc_queue.sv
src/ttc_div_lane.sv
src/ttc_back.sv
src/triangle_tangent_calc_unit.sv
verif/tb_triangle_tangent_calc_unit.sv
